@@ hw/rtl/matau_pkg.sv @@
// ----------------------------------------------------------------------------
// Moving average threshold alert unit package
// Shared widths, reset values, register indexes, alert codes, FSM states and command/status structs.
// ----------------------------------------------------------------------------
package matau_pkg;

	localparam int DATA_W          = 32;
	localparam int WINDOW_SIZE_DEF = 4;

	localparam logic signed [DATA_W-1:0] ALERT_HIGH_RST = 32'sd30000;
	localparam logic signed [DATA_W-1:0] ALERT_LOW_RST  = 32'sd15000;

	// Register index as decoded from the APB address.
	typedef enum logic [0:0] {
		REG_ALERT_HIGH = 1'b0,
		REG_ALERT_LOW  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ALERT_NONE = 2'd0,
		ALERT_HIGH = 2'd1,
		ALERT_LOW  = 2'd2
	} alert_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_UPD,
		S_LOAD,
		S_DIV,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;  // capture the incoming sample
		logic rd;      // read the window slot about to be overwritten
		logic upd;     // write the window, update running sum and fill count
		logic load;    // load the divider with |sum| and the fill count
		logic step;    // one restoring division step
		logic finish;  // compare, bump counters, load the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
	} stat_t;

endpackage

@@ hw/rtl/matau_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module matau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/matau_ctrl.sv @@
// ----------------------------------------------------------------------------
// Moving average threshold alert controller
// Sequences one sample through window update, division and result output.
// ----------------------------------------------------------------------------
module matau_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output matau_pkg::cmd_t  cmd,
	input  matau_pkg::stat_t stat
);

	import matau_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FIN: begin
				// Wait until the output register is free or being emptied.
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ hw/rtl/matau_dp.sv @@
// ----------------------------------------------------------------------------
// Moving average threshold alert datapath
// Window RAM, running sum, serial divider, threshold compare and counters.
// ----------------------------------------------------------------------------
module matau_dp #(
	parameter int WINDOW_SIZE = matau_pkg::WINDOW_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  matau_pkg::cmd_t               cmd,
	output matau_pkg::stat_t              stat,
	input  logic [matau_pkg::DATA_W-1:0]  sample_in,
	output logic [matau_pkg::DATA_W-1:0]  average,
	output logic [matau_pkg::DATA_W-1:0]  processed_count,
	output logic [matau_pkg::DATA_W-1:0]  alert_count,
	output logic [1:0]                    alert_code,
	input  logic                          cfg_we,
	input  matau_pkg::reg_idx_t           cfg_sel,
	input  logic [matau_pkg::DATA_W-1:0]  cfg_wdata,
	output logic [matau_pkg::DATA_W-1:0]  cfg_rdata
);

	import matau_pkg::*;

	localparam int AW    = $clog2(WINDOW_SIZE);
	localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
	localparam int SUM_W = DATA_W + AW;
	localparam int CW    = $clog2(SUM_W + 1);

	logic signed [DATA_W-1:0] alert_high_q;
	logic signed [DATA_W-1:0] alert_low_q;

	logic [DATA_W-1:0]       sample_q;
	logic [AW-1:0]           wpos_q;
	logic [CNT_W-1:0]        fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [DATA_W-1:0]       samples_q;
	logic [DATA_W-1:0]       alerts_q;

	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] div_q;
	logic [SUM_W-1:0] quo_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;

	logic [DATA_W-1:0]       old_sample;
	logic                    full;
	logic signed [SUM_W-1:0] sub_term;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0]        sum_mag;
	logic [CNT_W:0]          trial;
	logic                    trial_ge;
	logic signed [DATA_W-1:0] mean;
	alert_code_t             code;

	// Window storage; the slot read is the one about to be overwritten.
	matau_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW_SIZE)
	) u_window (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (wpos_q),
		.wdata (sample_q),
		.re    (cmd.rd),
		.raddr (wpos_q),
		.rdata (old_sample)
	);

	assign full     = (fill_q == CNT_W'(WINDOW_SIZE));
	assign sub_term = full ? SUM_W'($signed(old_sample)) : '0;
	assign sum_next = sum_q + SUM_W'($signed(sample_q)) - sub_term;
	assign sum_mag  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign trial_ge = (trial >= {1'b0, div_q});

	assign mean = neg_q ? (~quo_q[DATA_W-1:0] + 1'b1) : quo_q[DATA_W-1:0];

	always_comb begin
		if (mean > alert_high_q) begin
			code = ALERT_HIGH;
		end else if (mean < alert_low_q) begin
			code = ALERT_LOW;
		end else begin
			code = ALERT_NONE;
		end
	end

	assign stat.div_done = (cnt_q == '0);

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_high_q <= ALERT_HIGH_RST;
			alert_low_q  <= ALERT_LOW_RST;
			wpos_q       <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			samples_q    <= '0;
			alerts_q     <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_sel)
					REG_ALERT_HIGH: alert_high_q <= cfg_wdata;
					REG_ALERT_LOW:  alert_low_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.upd) begin
				sum_q  <= sum_next;
				wpos_q <= (wpos_q == AW'(WINDOW_SIZE - 1)) ? '0 : wpos_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.load) begin
				cnt_q <= CW'(SUM_W);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.finish) begin
				samples_q <= samples_q + 1'b1;
				if (code != ALERT_NONE) begin
					alerts_q <= alerts_q + 1'b1;
				end
			end
		end
	end

	// Payload registers: sample capture, divider and output register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample_in;
		end
		if (cmd.load) begin
			rem_q <= '0;
			div_q <= fill_q;
			quo_q <= sum_mag;
			neg_q <= sum_q[SUM_W-1];
		end else if (cmd.step) begin
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], trial_ge};
		end
		if (cmd.finish) begin
			average         <= mean;
			processed_count <= samples_q + 1'b1;
			alert_count     <= (code != ALERT_NONE) ? alerts_q + 1'b1 : alerts_q;
			alert_code      <= code;
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_ALERT_HIGH: cfg_rdata = alert_high_q;
			REG_ALERT_LOW:  cfg_rdata = alert_low_q;
			default:        cfg_rdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/moving_average_threshold_alert_unit.sv @@
// ----------------------------------------------------------------------------
// Moving average threshold alert unit
// Ring-window moving average of signed samples with high/low alarm checks.
// ----------------------------------------------------------------------------
//
// Channel    Dir   Handshake               Payload
// s_*        in    s_tvalid / s_tready     sample
// m_*        out   m_tvalid / m_tready     average, processed_count,
//                                          alert_count, alert_code
// APB        in    psel & penable & pwrite alert_high @ 0x0, alert_low @ 0x4
//
// One sample is in flight at a time. The input is not free again until the
// one-bit-per-cycle restoring divider has divided the running sum by the fill
// count and the result has been finished.
// A finished result waits in the output register while the next sample is
// accepted; the block only stalls at its final step if that register is
// still full. Reset clears the counters, fill count, write position, running
// sum, and presets the thresholds; window slots are only used once written.
// ----------------------------------------------------------------------------
module moving_average_threshold_alert_unit #(
	parameter int WINDOW_SIZE = matau_pkg::WINDOW_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// Input stream.
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,   // [31:0] sample
	// Output stream.
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [103:0]  m_tdata,   // [31:0] average, [63:32] processed_count,
	                                 // [95:64] alert_count, [97:96] alert_code,
	                                 // [103:98] zero
	// Configuration port.
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	import matau_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	logic [DATA_W-1:0] average;
	logic [DATA_W-1:0] processed_count;
	logic [DATA_W-1:0] alert_count;
	logic [1:0]        alert_code;
	logic              cfg_we;
	reg_idx_t          cfg_sel;

	// Registers sit on word boundaries; bit 2 selects between the two.
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg_sel = reg_idx_t'(paddr[2]);

	matau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	matau_dp #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.sample_in       (s_tdata),
		.average         (average),
		.processed_count (processed_count),
		.alert_count     (alert_count),
		.alert_code      (alert_code),
		.cfg_we          (cfg_we),
		.cfg_sel         (cfg_sel),
		.cfg_wdata       (pwdata),
		.cfg_rdata       (prdata)
	);

	assign m_tdata = {6'b0, alert_code, alert_count, processed_count, average};

	// Only one sample is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a sample is in flight");

	// A finished result always shows up on the output next cycle.
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("finished result not presented");

	// The divider is never stepped past its last quotient bit.
	a_no_overstep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !stat.div_done)
		else $error("divider stepped after completion");

	// A new sample is never captured in the cycle that a result is finished.
	a_finish_before_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !cmd.finish)
		else $error("accept and finish in the same cycle");

endmodule
